// ===== design/csfg_pkg.sv =====
// ----------------------------------------------------------------------------
// csfg_pkg
// Types and constants shared by the charger session controller.
// ----------------------------------------------------------------------------
`default_nettype none

package csfg_pkg;

    // Telemetry sample width (current, voltage, temperature)
    localparam int SAMPLE_WIDTH = 16;
    // Working width for threshold compares: wide enough for sample and limit
    localparam int LIM_W        = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
    localparam int DELTA_W      = 16;
    localparam int TIMER_W      = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic KIND_TELEMETRY = 1'b0;
    localparam logic KIND_CLEAR     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CONNECTED = 3'd1,
        ST_CHARGING  = 3'd2,
        ST_COMPLETE  = 3'd3,
        ST_FAULT     = 3'd4
    } t_session_state;

    typedef enum logic [2:0] {
        FLT_NONE         = 3'd0,
        FLT_OVER_CURRENT = 3'd1,
        FLT_OVER_VOLTAGE = 3'd2,
        FLT_OVER_TEMP    = 3'd3,
        FLT_LINK_TIMEOUT = 3'd4
    } t_fault_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_LIMIT     = 2'd0,
        CFG_VOLTAGE_LIMIT     = 2'd1,
        CFG_TEMPERATURE_LIMIT = 2'd2,
        CFG_LINK_TIMEOUT_MS   = 2'd3
    } t_cfg_index;

    localparam logic [15:0]        CURRENT_LIMIT_RST     = 16'd2000;
    localparam logic [15:0]        VOLTAGE_LIMIT_RST     = 16'd5000;
    localparam logic signed [15:0] TEMPERATURE_LIMIT_RST = 16'sd800;
    localparam logic [TIMER_W-1:0] LINK_TIMEOUT_MS_RST   = 32'd1000;

    typedef struct packed {
        logic                           kind;
        logic                           vehicle_connected;
        logic                           charge_requested;
        logic                           link_alive;
        logic [SAMPLE_WIDTH-1:0]        current_sample;
        logic [SAMPLE_WIDTH-1:0]        voltage_sample;
        logic signed [SAMPLE_WIDTH-1:0] temperature_sample;
        logic [DELTA_W-1:0]             delta_ms;
    } t_in_item;

    typedef struct packed {
        t_session_state charger_state;
        t_fault_code    fault_code;
        logic           contactor_closed;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        current_limit;
        logic [15:0]        voltage_limit;
        logic signed [15:0] temperature_limit;
        logic [TIMER_W-1:0] link_timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_session_state     state;
        t_fault_code        fault;
        logic               contactor;
        logic [TIMER_W-1:0] link_lost_ms;
    } t_session;

endpackage

`default_nettype wire

// ===== design/csfg_step.sv =====
// ----------------------------------------------------------------------------
// csfg_step
// One session step: link timer, prioritized fault check, session next state.
// ----------------------------------------------------------------------------
`default_nettype none

module csfg_step (
    input  wire csfg_pkg::t_in_item i_item,
    input  wire csfg_pkg::t_cfg     i_cfg,
    input  wire csfg_pkg::t_session i_sess,
    output csfg_pkg::t_session      o_sess
);
    import csfg_pkg::*;

    logic [TIMER_W:0]          w_sum;
    logic [TIMER_W-1:0]        w_lost;
    logic [LIM_W-1:0]          w_cur;
    logic [LIM_W-1:0]          w_cur_lim;
    logic [LIM_W-1:0]          w_volt;
    logic [LIM_W-1:0]          w_volt_lim;
    logic signed [LIM_W-1:0]   w_temp;
    logic signed [LIM_W-1:0]   w_temp_lim;
    t_fault_code               w_fault;

    // saturating lost-link timer
    assign w_sum  = {1'b0, i_sess.link_lost_ms} + (TIMER_W + 1)'(i_item.delta_ms);
    assign w_lost = i_item.link_alive ? '0
                  : (w_sum[TIMER_W] ? '1 : w_sum[TIMER_W-1:0]);

    assign w_cur      = LIM_W'(i_item.current_sample);
    assign w_cur_lim  = LIM_W'(i_cfg.current_limit);
    assign w_volt     = LIM_W'(i_item.voltage_sample);
    assign w_volt_lim = LIM_W'(i_cfg.voltage_limit);
    assign w_temp     = LIM_W'(i_item.temperature_sample);
    assign w_temp_lim = LIM_W'(i_cfg.temperature_limit);

    always_comb begin
        if (w_cur > w_cur_lim) begin
            w_fault = FLT_OVER_CURRENT;
        end else if (w_volt > w_volt_lim) begin
            w_fault = FLT_OVER_VOLTAGE;
        end else if (w_temp > w_temp_lim) begin
            w_fault = FLT_OVER_TEMP;
        end else if (w_lost >= i_cfg.link_timeout_ms) begin
            w_fault = FLT_LINK_TIMEOUT;
        end else begin
            w_fault = FLT_NONE;
        end
    end

    always_comb begin
        o_sess              = i_sess;
        o_sess.link_lost_ms = w_lost;
        o_sess.fault        = w_fault;
        o_sess.contactor    = 1'b0;
        if (i_item.kind == KIND_CLEAR) begin
            o_sess.state        = ST_IDLE;
            o_sess.fault        = FLT_NONE;
            o_sess.link_lost_ms = '0;
        end else if (w_fault != FLT_NONE) begin
            o_sess.state = ST_FAULT;
        end else begin
            unique case (i_sess.state)
                ST_CONNECTED: begin
                    if (!i_item.vehicle_connected) begin
                        o_sess.state = ST_IDLE;
                    end else if (i_item.charge_requested) begin
                        o_sess.state = ST_CHARGING;
                    end
                end
                ST_CHARGING: begin
                    if (!i_item.vehicle_connected) begin
                        o_sess.state = ST_IDLE;
                    end else if (!i_item.charge_requested) begin
                        o_sess.state = ST_COMPLETE;
                    end else begin
                        o_sess.contactor = 1'b1;
                    end
                end
                ST_COMPLETE: begin
                    if (!i_item.vehicle_connected) begin
                        o_sess.state = ST_IDLE;
                    end
                end
                ST_FAULT: begin
                    o_sess.state = ST_FAULT;
                end
                default: begin
                    o_sess.state = i_item.vehicle_connected ? ST_CONNECTED : ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/charger_session_fsm_with_fault_guard_unit.sv =====
// ----------------------------------------------------------------------------
// charger_session_fsm_with_fault_guard_unit
// Charger session controller with latched fault guard and lost-link timer.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Payload
//  --------  ------------------------------------  -------------------------
//  input     i_in_valid / o_in_stall               i_in_data  (t_in_item)
//  output    o_out_valid / i_out_stall             o_out_data (t_out_item)
//  config    i_cfg_we, i_cfg_index                 i_cfg_data (32 bit)
//
//  One transaction per cycle sustained while the output is not stalled. Path:
//  input register, then the step logic (fault compares, timer add, next state)
//  feeding the result register, which is also where session state is committed.
//  Synchronous active-low reset restores session state and limit registers.
//  A stall on the output holds the result register; the input register keeps
//  accepting until it too is full, so stall reaches o_in_stall after one item.
//
`default_nettype none

module charger_session_fsm_with_fault_guard_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input transaction channel
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire csfg_pkg::t_in_item             i_in_data,
    // result transaction channel
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output csfg_pkg::t_out_item                 o_out_data,
    // configuration writes
    input  wire                                 i_cfg_we,
    input  wire [csfg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [csfg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import csfg_pkg::*;

    t_cfg      r_cfg;
    t_session  r_sess;
    t_session  n_sess;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_advance;
    logic      w_in_take;

    // Stage 2 moves when the result register is empty or being drained.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_limit     <= CURRENT_LIMIT_RST;
            r_cfg.voltage_limit     <= VOLTAGE_LIMIT_RST;
            r_cfg.temperature_limit <= TEMPERATURE_LIMIT_RST;
            r_cfg.link_timeout_ms   <= LINK_TIMEOUT_MS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CURRENT_LIMIT:     r_cfg.current_limit     <= i_cfg_data[15:0];
                CFG_VOLTAGE_LIMIT:     r_cfg.voltage_limit     <= i_cfg_data[15:0];
                CFG_TEMPERATURE_LIMIT: r_cfg.temperature_limit <= i_cfg_data[15:0];
                CFG_LINK_TIMEOUT_MS:   r_cfg.link_timeout_ms   <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_in_data;
        end
    end

    // step logic: state is read from the committed register
    csfg_step u_step (
        .i_item (r_in_item),
        .i_cfg  (r_cfg),
        .i_sess (r_sess),
        .o_sess (n_sess)
    );

    // session state commits when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess.state        <= ST_IDLE;
            r_sess.fault        <= FLT_NONE;
            r_sess.contactor    <= 1'b0;
            r_sess.link_lost_ms <= '0;
        end else if (r_in_valid && w_advance) begin
            r_sess <= n_sess;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && w_advance) begin
            r_out_item.charger_state    <= n_sess.state;
            r_out_item.fault_code       <= n_sess.fault;
            r_out_item.contactor_closed <= n_sess.contactor;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire
